### rtl/euler_to_quaternion_core_defines.svh
// assertion helpers shared by the checker
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define E2Q_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/e2q_pkg.sv
`default_nettype none
package e2q_pkg;
    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int OUT_FRAC_BITS_DEF   = 14;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_W             = 15;
    localparam int QUAT_W              = 16;
    localparam int QW                  = 36;

    localparam logic signed [QW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [QW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [QW-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [QW-1:0] CORDIC_GAIN = 36'sh026DD3B6A;

    function automatic logic signed [QW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [QW-1:0] v;
        case (idx)
            5'd0:  v = 36'sh03243F6A8;
            5'd1:  v = 36'sh01DAC6705;
            5'd2:  v = 36'sh00FADBAFC;
            5'd3:  v = 36'sh007F56EA6;
            5'd4:  v = 36'sh003FEAB76;
            5'd5:  v = 36'sh001FFD55B;
            5'd6:  v = 36'sh000FFFAAA;
            5'd7:  v = 36'sh0007FFF55;
            5'd8:  v = 36'sh0003FFFEA;
            5'd9:  v = 36'sh0001FFFFD;
            5'd10: v = 36'sh0000FFFFF;
            5'd11: v = 36'sh00007FFFF;
            5'd12: v = 36'sh00003FFFF;
            5'd13: v = 36'sh00001FFFF;
            5'd14: v = 36'sh00000FFFF;
            5'd15: v = 36'sh000007FFF;
            5'd16: v = 36'sh000003FFF;
            5'd17: v = 36'sh000001FFF;
            5'd18: v = 36'sh000000FFF;
            5'd19: v = 36'sh0000007FF;
            5'd20: v = 36'sh0000003FF;
            5'd21: v = 36'sh0000001FF;
            5'd22: v = 36'sh0000000FF;
            5'd23: v = 36'sh00000007F;
            5'd24: v = 36'sh00000003F;
            5'd25: v = 36'sh00000001F;
            5'd26: v = 36'sh00000000F;
            5'd27: v = 36'sh000000008;
            5'd28: v = 36'sh000000004;
            5'd29: v = 36'sh000000002;
            5'd30: v = 36'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round a q30 pair product back to q30
    function automatic logic signed [QW-1:0] rnd_q30(input logic signed [2*QW-1:0] p);
        logic signed [2*QW-1:0] t;
        t = (p + (72'sd1 <<< 29)) >>> 30;
        return t[QW-1:0];
    endfunction
endpackage
`default_nettype wire

### rtl/e2q_if.sv
`default_nettype none
interface e2q_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/euler_to_quaternion_core.sv
// an input word passes half angle, fold, cordic, sin/cos, products and sums
// throughput: one word per cycle; every stage holds when the output is stalled
// the pipeline is a chain of stages with valid bits, a full stall freezes all
// reset (synchronous, active low) clears the valid bits; payload is not reset
// input data is {yaw, pitch, roll}; output data is {w, z, y, x}
`default_nettype none
module euler_to_quaternion_core
    import e2q_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    e2q_if.sink       i_in,
    e2q_if.source     o_out
);
    localparam int NS = CORDIC_STEPS + 6;
    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic signed [QW-1:0] LIM = QW'(1) <<< OUT_FRAC_BITS;

    logic          adv;
    logic [NS-1:0] r_vld;
    assign adv        = !r_vld[NS-1] || o_out.ready;
    assign i_in.ready = adv;
    assign o_out.valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    // stage 0: half angle in q30, reduction mod 2pi
    logic signed [QW-1:0] r_h [3];
    logic signed [QW-1:0] n_h [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [ANGLE_W-1:0] ang;
            logic signed [QW-1:0] t;
            ang = i_in.data[a*ANGLE_W +: ANGLE_W];
            t = QW'(ang) <<< (29 - ANGLE_FRAC_BITS);
            if (t >= Q30_PI) t = t - Q30_TWO_PI;
            if (t < -Q30_PI) t = t + Q30_TWO_PI;
            n_h[a] = t;
        end
    end
    always_ff @(posedge i_clk) if (adv) r_h <= n_h;

    // stage 1: fold into +-pi/2
    logic signed [QW-1:0] r_z0 [3];
    logic [2:0]           r_flip [CORDIC_STEPS+1];
    logic signed [QW-1:0] n_z0 [3];
    logic [2:0]           n_flip;
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_z0[a] = r_h[a];
            n_flip[a] = 1'b0;
            if (r_h[a] > Q30_HALF_PI) begin
                n_z0[a] = Q30_PI - r_h[a];
                n_flip[a] = 1'b1;
            end else if (r_h[a] < -Q30_HALF_PI) begin
                n_z0[a] = -Q30_PI - r_h[a];
                n_flip[a] = 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_z0 <= n_z0;
            r_flip[0] <= n_flip;
            for (int s = 1; s < CORDIC_STEPS + 1; s++) r_flip[s] <= r_flip[s-1];
        end
    end

    // cordic stages, one iteration per stage
    logic signed [QW-1:0] r_cx [CORDIC_STEPS+1][3];
    logic signed [QW-1:0] r_cy [CORDIC_STEPS+1][3];
    logic signed [QW-1:0] r_cz [CORDIC_STEPS+1][3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            r_cx[0][a] = CORDIC_GAIN;
            r_cy[0][a] = '0;
            r_cz[0][a] = r_z0[a];
        end
    end
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int a = 0; a < 3; a++) begin
                    if (r_cz[i][a] >= 0) begin
                        r_cx[i+1][a] <= r_cx[i][a] - (r_cy[i][a] >>> i);
                        r_cy[i+1][a] <= r_cy[i][a] + (r_cx[i][a] >>> i);
                        r_cz[i+1][a] <= r_cz[i][a] - atan_q30(5'(i));
                    end else begin
                        r_cx[i+1][a] <= r_cx[i][a] + (r_cy[i][a] >>> i);
                        r_cy[i+1][a] <= r_cy[i][a] - (r_cx[i][a] >>> i);
                        r_cz[i+1][a] <= r_cz[i][a] + atan_q30(5'(i));
                    end
                end
            end
        end
    end

    localparam int FI = CORDIC_STEPS + 1;
    // sin/cos: roll, pitch, yaw
    logic signed [QW-1:0] r_sn [3];
    logic signed [QW-1:0] r_cs [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                r_sn[a] <= r_cy[CORDIC_STEPS][a];
                r_cs[a] <= r_flip[FI-1][a] ? -r_cx[CORDIC_STEPS][a] : r_cx[CORDIC_STEPS][a];
            end
        end
    end

    // pair products: cr*cp, sr*sp, sr*cp, cr*sp; carry cy, sy
    logic signed [QW-1:0] r_pp [4];
    logic signed [QW-1:0] r_cy1, r_sy1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pp[0] <= rnd_q30(r_cs[0] * r_cs[1]);
            r_pp[1] <= rnd_q30(r_sn[0] * r_sn[1]);
            r_pp[2] <= rnd_q30(r_sn[0] * r_cs[1]);
            r_pp[3] <= rnd_q30(r_cs[0] * r_sn[1]);
            r_cy1 <= r_cs[2];
            r_sy1 <= r_sn[2];
        end
    end

    // triple products: 0 sr*cp*cy 1 cr*sp*sy 2 cr*sp*cy 3 sr*cp*sy
    // 4 cr*cp*sy 5 sr*sp*cy 6 cr*cp*cy 7 sr*sp*sy
    logic signed [QW-1:0] r_tp [8];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tp[0] <= rnd_q30(r_pp[2] * r_cy1);
            r_tp[1] <= rnd_q30(r_pp[3] * r_sy1);
            r_tp[2] <= rnd_q30(r_pp[3] * r_cy1);
            r_tp[3] <= rnd_q30(r_pp[2] * r_sy1);
            r_tp[4] <= rnd_q30(r_pp[0] * r_sy1);
            r_tp[5] <= rnd_q30(r_pp[1] * r_cy1);
            r_tp[6] <= rnd_q30(r_pp[0] * r_cy1);
            r_tp[7] <= rnd_q30(r_pp[1] * r_sy1);
        end
    end

    // sums, round, saturate
    logic signed [QW-1:0] n_sum [4];
    logic [QUAT_W-1:0]    r_q [4];
    always_comb begin
        n_sum[0] = r_tp[0] - r_tp[1];
        n_sum[1] = r_tp[2] + r_tp[3];
        n_sum[2] = r_tp[4] - r_tp[5];
        n_sum[3] = r_tp[6] + r_tp[7];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                logic signed [QW:0] v;
                v = (QW+1)'(n_sum[k]);
                if (SH > 0) v = (v + ((QW+1)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
                if (v > (QW+1)'(LIM)) v = (QW+1)'(LIM);
                if (v < -(QW+1)'(LIM)) v = -(QW+1)'(LIM);
                r_q[k] <= v[QUAT_W-1:0];
            end
        end
    end

    assign o_out.data = {r_q[3], r_q[2], r_q[1], r_q[0]};
endmodule
`default_nettype wire

### rtl/e2q_checker.sv
`default_nettype none
`include "euler_to_quaternion_core_defines.svh"
module e2q_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_data
);
    `E2Q_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed under stall")
    `E2Q_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !out_valid, in_ready, "input stalled with empty output")
    `E2Q_ASSERT_IMPL(a_stall, i_clk, i_rst_n, out_valid && !out_ready, !in_ready, "input taken during full stall")
    `E2Q_ASSERT_IMPL(a_w, i_clk, i_rst_n, out_valid, !out_data[63] || out_data[63:48] >= 16'hC000, "w below minus one")
endmodule
bind euler_to_quaternion_core e2q_checker u_e2q_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_data  (o_out.data)
);
`default_nettype wire
